/* rtl/pdid_pkg.sv */
// Shared types, constants and table functions for the packed diffraction image decoder.
package pdid_pkg;

    localparam int DEF_MAX_WIDTH     = 4096;
    localparam int ROWW_W            = 13;
    localparam int CNT_W             = 25;
    localparam int IDX_W             = 25;
    localparam int CFG_DATA_W        = 25;
    localparam int WIN_BITS          = 40;
    localparam int HELD_W            = 6;
    localparam int HDR_BITS          = 6;
    localparam int PIX_W             = 16;
    localparam int RUN_W             = 8;
    localparam int FW_W              = 6;
    localparam int RESET_ROW_WIDTH   = 3450;
    localparam int RESET_PIXEL_COUNT = 11902500;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_PIXEL   = 2'd1,
        OP_RESTART = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic {
        CFG_ROW_WIDTH   = 1'b0,
        CFG_PIXEL_COUNT = 1'b1
    } t_cfg_reg;

    // Run length selected by the low three header bits.
    function automatic logic [RUN_W-1:0] run_len(input logic [2:0] code);
        logic [RUN_W-1:0] len;
        unique case (code)
            3'd0:    len = 8'd1;
            3'd1:    len = 8'd2;
            3'd2:    len = 8'd4;
            3'd3:    len = 8'd8;
            3'd4:    len = 8'd16;
            3'd5:    len = 8'd32;
            3'd6:    len = 8'd64;
            default: len = 8'd128;
        endcase
        return len;
    endfunction

    // Error field width selected by the high three header bits.
    function automatic logic [FW_W-1:0] field_bits(input logic [2:0] code);
        logic [FW_W-1:0] bits;
        unique case (code)
            3'd0:    bits = 6'd0;
            3'd1:    bits = 6'd4;
            3'd2:    bits = 6'd5;
            3'd3:    bits = 6'd6;
            3'd4:    bits = 6'd7;
            3'd5:    bits = 6'd8;
            3'd6:    bits = 6'd16;
            default: bits = 6'd32;
        endcase
        return bits;
    endfunction

    // Low 16 bits of the sign-extended error field; zero width reads as 0.
    function automatic logic [PIX_W-1:0] field_err(input logic [2:0] code,
                                                   input logic [31:0] x);
        logic [PIX_W-1:0] e;
        unique case (code)
            3'd0:    e = '0;
            3'd1:    e = {{12{x[3]}}, x[3:0]};
            3'd2:    e = {{11{x[4]}}, x[4:0]};
            3'd3:    e = {{10{x[5]}}, x[5:0]};
            3'd4:    e = {{9{x[6]}}, x[6:0]};
            3'd5:    e = {{8{x[7]}}, x[7:0]};
            default: e = x[15:0];
        endcase
        return e;
    endfunction

endpackage

/* rtl/packed_diffraction_image_decoder.sv */
// Packed diffraction image decoder: bit window, run/field decode, predictor and line store.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+---------------------------------------------------
//  item in   | in  | i_valid / o_stall  | i_operation, i_packed_byte
//  result    | out | o_valid / i_stall  | o_pixel_value, o_pixel_valid, o_need_byte,
//            |     |                    | o_byte_dropped, o_image_done
//  config    | in  | i_cfg_we           | i_cfg_index, i_cfg_data
//
//  One beat in per cycle while o_stall is low; its result beat is shown in the next cycle from the output register.
//  After reset, a restart beat or a config write, the block stalls input while
//  the three-entry neighbour window is reloaded from the line store (one read port).
//  Each pixel issues one line-store read for the next window entry; the other neighbours
//  come from the sliding window and the previous-pixel register.
//  Reset is synchronous, active low; the line store itself is not cleared.
//  A stalled result beat holds; input stalls while that beat is still held and during a reload.
module packed_diffraction_image_decoder #(
    parameter int MAX_WIDTH = pdid_pkg::DEF_MAX_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // item in
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_operation,
    input  logic [7:0]                      i_packed_byte,
    // result out
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [pdid_pkg::PIX_W-1:0]      o_pixel_value,
    output logic                            o_pixel_valid,
    output logic                            o_need_byte,
    output logic                            o_byte_dropped,
    output logic                            o_image_done,
    // config
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_index,
    input  logic [pdid_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int RING     = MAX_WIDTH + 1;            // line store depth
    localparam int PW       = $clog2(RING);             // ring pointer / address width
    localparam int CW       = (PW > pdid_pkg::ROWW_W) ? PW : pdid_pkg::ROWW_W;
    localparam int IDX_W    = pdid_pkg::IDX_W;
    localparam int CNT_W    = pdid_pkg::CNT_W;
    localparam int ROWW_W   = pdid_pkg::ROWW_W;
    localparam int WIN_BITS = pdid_pkg::WIN_BITS;
    localparam int HELD_W   = pdid_pkg::HELD_W;
    localparam int HDR_BITS = pdid_pkg::HDR_BITS;
    localparam int PIX_W    = pdid_pkg::PIX_W;
    localparam int RUN_W    = pdid_pkg::RUN_W;
    localparam int FW_W     = pdid_pkg::FW_W;

    function automatic logic [PW-1:0] ring_wrap(input logic [PW:0] x);
        logic [PW:0] y;
        y = (x >= (PW+1)'(RING)) ? x - (PW+1)'(RING) : x;
        return y[PW-1:0];
    endfunction

    // config registers
    logic [ROWW_W-1:0]   r_row_width;
    logic [CNT_W-1:0]    r_pixel_count;

    // decode state
    logic [WIN_BITS-1:0] r_win,  n_win;
    logic [HELD_W-1:0]   r_held, n_held;
    logic [RUN_W-1:0]    r_run,  n_run;
    logic [2:0]          r_code, n_code;
    logic [IDX_W-1:0]    r_pidx, n_pidx;
    logic [PW-1:0]       r_rp,   n_rp;
    logic [PIX_W-1:0]    r_prev;

    // neighbour window: far = back W+1, mid = back W, near = back W-1
    logic [PIX_W-1:0]    r_nb_far, r_nb_mid, r_nb_near;
    logic                r_near_pend;               // near arrives from this cycle's read data
    logic                r_filling;
    logic [1:0]          r_fill_cnt;

    // line store
    logic [PIX_W-1:0]    r_line_mem [RING];
    logic [PIX_W-1:0]    r_rd_data;
    logic [PW-1:0]       rd_addr;

    // output register
    logic                r_out_valid;
    logic [PIX_W-1:0]    r_pixel_value;
    logic                r_pixel_valid;
    logic                r_byte_dropped;

    pdid_pkg::t_op       op;
    logic                acc;
    logic                done;
    logic [CW-1:0]       rw_ext;
    logic [PW-1:0]       w_eff;
    logic                w_is1, w_is2;

    logic                hdr_take;
    logic [2:0]          code_eff;
    logic [RUN_W-1:0]    run_eff;
    logic [HELD_W-1:0]   held_a;
    logic [WIN_BITS-1:0] win_a;
    logic [FW_W-1:0]     fw;
    logic                pix_go;
    logic [HELD_W-1:0]   sh;
    logic                dropped;

    logic [PIX_W-1:0]    near_eff;
    logic [PIX_W-1:0]    err;
    logic signed [18:0]  nb_sum;
    logic [18:0]         nb_adj;
    logic [PIX_W-1:0]    pred;
    logic [PIX_W-1:0]    value;
    logic [PW-1:0]       near_addr, fill_addr;

    assign op  = pdid_pkg::t_op'(i_operation);
    assign acc = i_valid && !o_stall;
    assign o_stall = r_filling || (r_out_valid && i_stall);

    assign done = ({1'b0, r_pidx[IDX_W-2:0]} == r_pidx) ?
                  (CNT_W'(r_pidx) >= r_pixel_count) : 1'b1;

    // effective row width: 0 -> 1, above the store limit -> limit
    assign rw_ext = CW'(r_row_width);
    always_comb begin
        if (r_row_width == '0) begin
            w_eff = PW'(1);
        end else if (rw_ext > CW'(MAX_WIDTH)) begin
            w_eff = PW'(MAX_WIDTH);
        end else begin
            w_eff = PW'(rw_ext);
        end
    end
    assign w_is1 = (w_eff == PW'(1));
    assign w_is2 = (w_eff == PW'(2));

    // header and field decode
    assign hdr_take = acc && (op == pdid_pkg::OP_PIXEL) && !done && (r_run == '0) &&
                      (r_held >= HELD_W'(HDR_BITS));
    assign code_eff = hdr_take ? r_win[5:3] : r_code;
    assign run_eff  = hdr_take ? pdid_pkg::run_len(r_win[2:0]) : r_run;
    assign held_a   = hdr_take ? r_held - HELD_W'(HDR_BITS) : r_held;
    assign win_a    = hdr_take ? (r_win >> HDR_BITS) : r_win;
    assign fw       = pdid_pkg::field_bits(code_eff);
    assign pix_go   = acc && (op == pdid_pkg::OP_PIXEL) && !done && (run_eff != '0) &&
                      (held_a >= fw);
    assign sh       = (hdr_take ? HELD_W'(HDR_BITS) : '0) + (pix_go ? fw : '0);
    assign dropped  = r_held > HELD_W'(WIN_BITS - 8);

    // predictor
    assign near_eff = r_near_pend ? r_rd_data : r_nb_near;
    assign err      = pdid_pkg::field_err(code_eff, win_a[31:0]);
    assign nb_sum   = $signed({{3{r_prev[15]}},    r_prev})
                    + $signed({{3{near_eff[15]}},  near_eff})
                    + $signed({{3{r_nb_mid[15]}},  r_nb_mid})
                    + $signed({{3{r_nb_far[15]}},  r_nb_far})
                    + 19'sd2;
    // truncate toward zero: bias negative sums by 3 before the shift
    assign nb_adj   = nb_sum + {17'd0, nb_sum[18], nb_sum[18]};

    always_comb begin
        if (r_pidx > IDX_W'(w_eff)) begin
            pred = nb_adj[17:2];
        end else if (r_pidx != '0) begin
            pred = r_prev;
        end else begin
            pred = '0;
        end
    end
    assign value = err + pred;

    // next pixel's near entry sits W-1 places behind the pointer after this write
    assign near_addr = ring_wrap((PW+1)'(n_rp) + (PW+1)'(RING + 1) - (PW+1)'(w_eff));
    assign fill_addr = ring_wrap((PW+1)'(r_rp) + (PW+1)'(MAX_WIDTH) - (PW+1)'(w_eff)
                                 + (PW+1)'(r_fill_cnt));
    assign rd_addr   = r_filling ? fill_addr : near_addr;

    // next decode state
    always_comb begin
        n_win  = r_win;
        n_held = r_held;
        n_run  = r_run;
        n_code = r_code;
        n_pidx = r_pidx;
        n_rp   = r_rp;
        if (acc) begin
            unique case (op)
                pdid_pkg::OP_PUSH: begin
                    if (!dropped) begin
                        n_win  = r_win | (WIN_BITS'(i_packed_byte) << r_held);
                        n_held = r_held + HELD_W'(8);
                    end
                end
                pdid_pkg::OP_PIXEL: begin
                    n_win  = r_win >> sh;
                    n_held = r_held - sh;
                    n_code = code_eff;
                    n_run  = run_eff;
                    if (pix_go) begin
                        n_run  = run_eff - RUN_W'(1);
                        n_pidx = r_pidx + IDX_W'(1);
                        n_rp   = (r_rp == PW'(RING - 1)) ? '0 : r_rp + PW'(1);
                    end
                end
                pdid_pkg::OP_RESTART: begin
                    n_win  = '0;
                    n_held = '0;
                    n_run  = '0;
                    n_code = '0;
                    n_pidx = '0;
                    n_rp   = '0;
                end
                pdid_pkg::OP_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width   <= ROWW_W'(pdid_pkg::RESET_ROW_WIDTH);
            r_pixel_count <= CNT_W'(pdid_pkg::RESET_PIXEL_COUNT);
            r_win         <= '0;
            r_held        <= '0;
            r_run         <= '0;
            r_code        <= '0;
            r_pidx        <= '0;
            r_rp          <= '0;
            r_filling     <= 1'b1;
            r_fill_cnt    <= '0;
            r_near_pend   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_win  <= n_win;
            r_held <= n_held;
            r_run  <= n_run;
            r_code <= n_code;
            r_pidx <= n_pidx;
            r_rp   <= n_rp;

            if (i_cfg_we) begin
                unique case (pdid_pkg::t_cfg_reg'(i_cfg_index))
                    pdid_pkg::CFG_ROW_WIDTH:   r_row_width   <= i_cfg_data[ROWW_W-1:0];
                    pdid_pkg::CFG_PIXEL_COUNT: r_pixel_count <= i_cfg_data[CNT_W-1:0];
                    default: begin
                    end
                endcase
            end

            // window reload after a restart beat, which resets the pointer, or any config write
            if (i_cfg_we || (acc && op == pdid_pkg::OP_RESTART)) begin
                r_filling   <= 1'b1;
                r_fill_cnt  <= '0;
                r_near_pend <= 1'b0;
            end else if (r_filling) begin
                r_fill_cnt <= r_fill_cnt + 2'd1;
                if (r_fill_cnt == 2'd3) begin
                    r_filling <= 1'b0;
                end
            end else if (pix_go) begin
                r_near_pend <= !w_is2;
            end else begin
                r_near_pend <= 1'b0;
            end

            if (acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (pix_go) begin
            r_prev   <= value;
            r_nb_far <= r_nb_mid;
            r_nb_mid <= w_is1 ? value : near_eff;
            r_nb_near <= value;
        end else if (r_filling) begin
            unique case (r_fill_cnt)
                2'd1:    r_nb_far  <= r_rd_data;
                2'd2:    r_nb_mid  <= r_rd_data;
                2'd3:    r_nb_near <= r_rd_data;
                default: begin
                end
            endcase
        end else if (r_near_pend) begin
            r_nb_near <= r_rd_data;
        end

        if (acc) begin
            r_pixel_value  <= pix_go ? value : '0;
            r_pixel_valid  <= pix_go;
            r_byte_dropped <= (op == pdid_pkg::OP_PUSH) && dropped;
        end
    end

    // line store: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (pix_go) begin
            r_line_mem[r_rp] <= value;
        end
        r_rd_data <= r_line_mem[rd_addr];
    end

    // status follows the state left by the beat on display
    assign o_valid        = r_out_valid;
    assign o_pixel_value  = r_pixel_value;
    assign o_pixel_valid  = r_pixel_valid;
    assign o_byte_dropped = r_byte_dropped;
    assign o_image_done   = done;
    assign o_need_byte    = !done &&
        ((r_run == '0) ?
            ({1'b0, r_held} < (7'(HDR_BITS) + {1'b0, pdid_pkg::field_bits(r_win[5:3])})) :
            (r_held < pdid_pkg::field_bits(r_code)));

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && op == pdid_pkg::OP_RESTART |=> r_filling && r_pidx == '0 && r_held == '0)
        else $error("restart did not clear decode state");

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HELD_W'(WIN_BITS))
        else $error("bit window overfilled");

    a_no_pixel_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && op == pdid_pkg::OP_PIXEL && done |=> r_out_valid && !r_pixel_valid)
        else $error("pixel produced after image done");

    a_pixel_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_pixel_valid |-> r_pidx != '0)
        else $error("pixel shown without advancing index");

    a_fill_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filling |-> !r_near_pend)
        else $error("pending window read during reload");

endmodule
